>>> sv/bit_stream_pack_unpack_buffer_assert.svh
// Assertion macros for the bit stream buffer.
// No dependencies; included by the top level only.
`ifndef BIT_STREAM_PACK_UNPACK_BUFFER_ASSERT_SVH
`define BIT_STREAM_PACK_UNPACK_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define BSPB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bspb assertion failed");
`define BSPB_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bspb forbidden condition");
`else
`define BSPB_ASSERT(label, prop)
`define BSPB_NEVER(label, expr)
`endif
`endif

>>> sv/bspb_pkg.sv
// Shared constants, types and helpers for the bit stream buffer.
// No dependencies.
package bspb_pkg;

  localparam int CAPACITY_BITS = 65536;
  localparam int WORD_BITS     = 64;
  localparam int OFF_W         = $clog2(WORD_BITS);
  localparam int WORDS         = CAPACITY_BITS / WORD_BITS;
  localparam int WORD_AW       = $clog2(WORDS);
  localparam int BANK_DEPTH    = WORDS / 2;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int POS_W         = 17;
  localparam int WIDTH_W       = 7;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_SEEK_RD = 2'd2,
    KIND_SEEK_WR = 2'd3
  } kind_t;

  localparam logic [2:0] WCODE_1  = 3'd0;
  localparam logic [2:0] WCODE_8  = 3'd1;
  localparam logic [2:0] WCODE_16 = 3'd2;
  localparam logic [2:0] WCODE_32 = 3'd3;
  localparam logic [2:0] WCODE_64 = 3'd4;

  typedef struct packed {
    logic               load_item;
    logic               rd_mem;
    logic               commit;
    logic               clr;
    logic [BANK_AW-1:0] clr_addr;
  } cmd_t;

  // Access width in bits; zero for unused codes.
  function automatic logic [WIDTH_W-1:0] width_of(input logic [2:0] code);
    logic [WIDTH_W-1:0] w;
    unique case (code)
      WCODE_1:  w = WIDTH_W'(1);
      WCODE_8:  w = WIDTH_W'(8);
      WCODE_16: w = WIDTH_W'(16);
      WCODE_32: w = WIDTH_W'(32);
      WCODE_64: w = WIDTH_W'(64);
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> sv/bspb_ctrl.sv
// Sequencer for the bit stream buffer: clear sweep, access and commit steps.
// Depends on bspb_pkg.
module bspb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bspb_pkg::cmd_t   cmd
);
  import bspb_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [BANK_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               commit_go;
  logic               accept;

  assign commit_go = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE) || commit_go;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + BANK_AW'(1);
        if (clr_cnt_r == BANK_AW'(BANK_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_nxt = in_valid ? ST_ACCESS : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    cmd.load_item = accept;
    cmd.rd_mem    = (state_r == ST_ACCESS);
    cmd.commit    = commit_go;
    cmd.clr       = (state_r == ST_CLEAR);
    cmd.clr_addr  = clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/bspb_dp.sv
// Datapath of the bit stream buffer: pointers, two word banks, merge and extract.
// Depends on bspb_pkg.
module bspb_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bspb_pkg::cmd_t              cmd,
  input  logic [1:0]                  in_kind,
  input  logic [2:0]                  in_width_code,
  input  logic [63:0]                 in_write_data,
  input  logic [bspb_pkg::POS_W-1:0]  in_position,
  output logic [63:0]                 out_read_data,
  output logic                        out_ok,
  output logic [bspb_pkg::POS_W-1:0]  out_read_position,
  output logic [bspb_pkg::POS_W-1:0]  out_write_position
);
  import bspb_pkg::*;

  // Even words live in one bank, odd words in the other, so both words of a
  // window of two neighboring words are read together and written together.
  logic [WORD_BITS-1:0] even_mem [BANK_DEPTH];
  logic [WORD_BITS-1:0] odd_mem  [BANK_DEPTH];
  logic [WORD_BITS-1:0] even_q_r, odd_q_r;

  kind_t              kind_r;
  logic [2:0]         wcode_r;
  logic [63:0]        data_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   rp_r, rp_nxt, wp_r, wp_nxt;
  logic [63:0]        rd_data_r, rd_data_nxt;
  logic               ok_r, ok_nxt;

  logic [POS_W-1:0]   acc_pos;
  logic [WORD_AW-1:0] word_idx;
  logic               k_odd;
  logic [BANK_AW-1:0] even_a, odd_a, even_wa, odd_wa;
  logic [OFF_W-1:0]   off;
  logic [WIDTH_W-1:0] w;
  logic               fits;
  logic [63:0]        wmask;
  logic [127:0]       win, win_sh, mask_sh, data_sh, merged;
  logic               mem_we;
  logic [63:0]        even_wd, odd_wd;

  assign acc_pos  = (kind_r == KIND_READ) ? rp_r : wp_r;
  assign word_idx = acc_pos[OFF_W +: WORD_AW];
  assign k_odd    = word_idx[0];
  assign odd_a    = word_idx[WORD_AW-1:1];
  // Wraps at the top word; the upper half is untouched there.
  assign even_a   = word_idx[WORD_AW-1:1] + BANK_AW'(k_odd);
  assign off      = acc_pos[OFF_W-1:0];
  assign w        = width_of(wcode_r);

  assign fits = (w != '0) &&
                (({1'b0, acc_pos} + (POS_W + 1)'(w)) <= (POS_W + 1)'(CAPACITY_BITS));

  assign wmask   = (w == WIDTH_W'(64)) ? '1 : ((64'd1 << w) - 64'd1);
  assign win     = k_odd ? {even_q_r, odd_q_r} : {odd_q_r, even_q_r};
  assign win_sh  = win >> off;
  assign mask_sh = {64'd0, wmask} << off;
  assign data_sh = {64'd0, data_r} << off;
  assign merged  = (win & ~mask_sh) | (data_sh & mask_sh);

  always_comb begin
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    rd_data_nxt = '0;
    ok_nxt      = 1'b0;
    case (kind_r)
      KIND_WRITE: begin
        if (fits) begin
          wp_nxt = wp_r + POS_W'(w);
          ok_nxt = 1'b1;
        end
      end
      KIND_READ: begin
        if (fits && !((w == WIDTH_W'(1)) && (rp_r >= wp_r))) begin
          rp_nxt      = rp_r + POS_W'(w);
          rd_data_nxt = win_sh[63:0] & wmask;
          ok_nxt      = 1'b1;
        end
      end
      KIND_SEEK_RD: begin
        rp_nxt = pos_r;
        ok_nxt = 1'b1;
      end
      default: begin
        wp_nxt = pos_r;
        ok_nxt = 1'b1;
      end
    endcase
  end

  assign mem_we  = cmd.clr || (cmd.commit && (kind_r == KIND_WRITE) && ok_nxt);
  assign even_wa = cmd.clr ? cmd.clr_addr : even_a;
  assign odd_wa  = cmd.clr ? cmd.clr_addr : odd_a;
  assign even_wd = cmd.clr ? '0 : (k_odd ? merged[127:64] : merged[63:0]);
  assign odd_wd  = cmd.clr ? '0 : (k_odd ? merged[63:0] : merged[127:64]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      even_mem[even_wa] <= even_wd;
    end
    if (cmd.rd_mem) begin
      even_q_r <= even_mem[even_a];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      odd_mem[odd_wa] <= odd_wd;
    end
    if (cmd.rd_mem) begin
      odd_q_r <= odd_mem[odd_a];
    end
  end

  // Hold the accepted item until its commit.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r  <= kind_t'(in_kind);
      wcode_r <= in_width_code;
      data_r  <= in_write_data;
      pos_r   <= in_position;
    end
    if (cmd.commit) begin
      rd_data_r <= rd_data_nxt;
      ok_r      <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
    end else if (cmd.commit) begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
    end
  end

  assign out_read_data      = rd_data_r;
  assign out_ok             = ok_r;
  assign out_read_position  = rp_r;
  assign out_write_position = wp_r;

endmodule

>>> sv/bit_stream_pack_unpack_buffer.sv
// Top level of the bit stream buffer: controller plus datapath.
// Depends on bspb_pkg, bspb_ctrl, bspb_dp and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: write bits,
//   read bits, set read position or set write position. Output channel
//   (out_valid/out_ready) returns exactly one result item per command with
//   the read data, the ok flag and both positions after the command.
//   Accesses are 1, 8, 16, 32 or 64 bits, least significant bit first, at
//   any bit position. The store is two banks of 64-bit words (even and odd
//   words), so an unaligned access reads both words of its window together
//   in its access step and writes them back merged in its commit step.
//   Order: an item goes through the access and commit steps; its result is
//   registered in the output register. The next item is accepted as the last
//   commits, paced by the read then merge-write pass over the word banks.
//   Reset: both positions go to zero and a clearing pass zeroes the store,
//   one word per bank per cycle over its 512 words; in_ready stays low during it.
//   Stall: a waiting result sits in the output register; the next item is
//   accepted and read from the banks, then holds in its commit step until
//   the receiver takes the waiting result.
`include "bit_stream_pack_unpack_buffer_assert.svh"
module bit_stream_pack_unpack_buffer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [2:0]                  in_width_code,
  input  logic [63:0]                 in_write_data,
  input  logic [bspb_pkg::POS_W-1:0]  in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_read_data,
  output logic                        out_ok,
  output logic [bspb_pkg::POS_W-1:0]  out_read_position,
  output logic [bspb_pkg::POS_W-1:0]  out_write_position
);
  import bspb_pkg::*;

  cmd_t cmd;

  // Sequence clear, access and commit; own the result valid flag.
  bspb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, word banks and the shift/merge logic.
  bspb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_kind            (in_kind),
    .in_width_code      (in_width_code),
    .in_write_data      (in_write_data),
    .in_position        (in_position),
    .out_read_data      (out_read_data),
    .out_ok             (out_ok),
    .out_read_position  (out_read_position),
    .out_write_position (out_write_position)
  );

  // One item in flight: no second accept right after an accept.
  `BSPB_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)
  // Every accepted item is followed by a valid result.
  `BSPB_ASSERT(a_result_follows, in_valid && in_ready |-> ##3 out_valid)
  // A refused or non-read command returns zero data.
  `BSPB_ASSERT(a_refused_zero, cmd.commit |=> out_valid && (out_ok || out_read_data == 64'd0))
  // Never clear the store while an item commits or is accepted.
  `BSPB_NEVER(a_no_commit_in_clear, cmd.clr && (cmd.commit || cmd.load_item))

endmodule

>>> verif/testbench.sv
// Self-checking testbench for bit_stream_pack_unpack_buffer.
// Holds its own bit-level store and both positions in a scoreboard class.
// Drives bursty command traffic against a stalling receiver; depends on bspb_pkg.
module testbench;
  import bspb_pkg::*;

  // Watchdog: cycles in which no item moves on either channel. Covers the
  // clearing pass after reset plus the longest sender gap and receiver stall.
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 8;

  // Width codes that the block must refuse for reads and writes.
  localparam logic [2:0] WCODE_SPARE_A = 3'd5;
  localparam logic [2:0] WCODE_SPARE_B = 3'd6;
  localparam logic [2:0] WCODE_SPARE_C = 3'd7;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef struct {
    logic [63:0]      read_data;
    logic             ok;
    logic [POS_W-1:0] read_position;
    logic [POS_W-1:0] write_position;
  } bit_result_t;

  // Bit-level copy of the store plus both positions; one result per command.
  class bit_stream_scoreboard;
    bit               store_bits [CAPACITY_BITS];
    logic [POS_W-1:0] rd_ptr;
    logic [POS_W-1:0] wr_ptr;
    bit_result_t      pending_q [$];
    int               errors;

    function new();
      rd_ptr = '0;
      wr_ptr = '0;
      errors = 0;
    endfunction

    function int unsigned access_bits(logic [2:0] code);
      case (code)
        WCODE_1:  return 1;
        WCODE_8:  return 8;
        WCODE_16: return 16;
        WCODE_32: return 32;
        WCODE_64: return 64;
        default:  return 0;
      endcase
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_item(kind_t k, logic [2:0] wc, logic [63:0] data,
                            logic [POS_W-1:0] pos);
      int unsigned nbits;
      bit          fits;
      bit_result_t r;
      nbits = access_bits(wc);
      r.read_data = '0;
      r.ok = 1'b0;
      case (k)
        KIND_WRITE: begin
          // Refuse unused widths and anything that would pass capacity.
          if (nbits != 0 && int'(wr_ptr) + nbits <= CAPACITY_BITS) begin
            for (int i = 0; i < nbits; i++) store_bits[int'(wr_ptr) + i] = data[i];
            wr_ptr = POS_W'(int'(wr_ptr) + nbits);
            r.ok = 1'b1;
          end
        end
        KIND_READ: begin
          fits = nbits != 0 && int'(rd_ptr) + nbits <= CAPACITY_BITS;
          // A single-bit read must stay below the write position.
          if (nbits == 1 && rd_ptr >= wr_ptr) fits = 1'b0;
          if (fits) begin
            for (int i = 0; i < nbits; i++) r.read_data[i] = store_bits[int'(rd_ptr) + i];
            rd_ptr = POS_W'(int'(rd_ptr) + nbits);
            r.ok = 1'b1;
          end
        end
        KIND_SEEK_RD: begin
          rd_ptr = pos;
          r.ok = 1'b1;
        end
        default: begin
          wr_ptr = pos;
          r.ok = 1'b1;
        end
      endcase
      r.read_position  = rd_ptr;
      r.write_position = wr_ptr;
      pending_q.push_back(r);
    endfunction

    // Compare one accepted result against the oldest queued one.
    function void check_result(logic [63:0] rd, logic ok, logic [POS_W-1:0] rp,
                               logic [POS_W-1:0] wp);
      bit_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending: data %h ok %b rpos %0d wpos %0d",
                 $time, rd, ok, rp, wp);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (rd !== e.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, rd);
        errors++;
      end
      if (ok !== e.ok) begin
        $display("%0t: ok expected %b actual %b", $time, e.ok, ok);
        errors++;
      end
      if (rp !== e.read_position) begin
        $display("%0t: read_position expected %0d actual %0d", $time, e.read_position, rp);
        errors++;
      end
      if (wp !== e.write_position) begin
        $display("%0t: write_position expected %0d actual %0d", $time, e.write_position, wp);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_kind = KIND_WRITE;
  logic [2:0]       in_width_code = WCODE_1;
  logic [63:0]      in_write_data = '0;
  logic [POS_W-1:0] in_position = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      out_read_data;
  logic             out_ok;
  logic [POS_W-1:0] out_read_position;
  logic [POS_W-1:0] out_write_position;

  bit_stream_scoreboard sb = new();

  bit_stream_pack_unpack_buffer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_width_code      (in_width_code),
    .in_write_data      (in_write_data),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_ok             (out_ok),
    .out_read_position  (out_read_position),
    .out_write_position (out_write_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender burst state: items left in this burst.
  int burst_left = 0;

  // Present one item and hold it until the block takes it, then log it.
  task automatic drive_item(kind_t k, logic [2:0] wc, logic [63:0] d,
                            logic [POS_W-1:0] p);
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_width_code <= wc;
    in_write_data <= d;
    in_position   <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, wc, d, p);
  endtask

  // Wrap each item in burst pacing: drop valid for a random gap between bursts,
  // and sometimes run a burst back to back with no gap at all.
  task automatic send_item(kind_t k, logic [2:0] wc, logic [63:0] d,
                           logic [POS_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    drive_item(k, wc, d, p);
  endtask

  function automatic logic [63:0] rand_data();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, 32'h1FFFF));
  endfunction

  // Build one random command. Most traffic is reads and writes in a small
  // window so reads see written data; seeks pull the pointers back, with a
  // few near the capacity edge, beyond it, and bad width codes as noise.
  task automatic send_random_item();
    int          sel;
    kind_t       k;
    logic [2:0]  wc;
    logic [POS_W-1:0] p;
    sel = $urandom_range(0, 99);
    wc  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                      : 3'($urandom_range(0, 4));
    p   = rand_pos();
    if (sel < 46) begin
      k = KIND_WRITE;
    end else if (sel < 86) begin
      k = KIND_READ;
    end else if (sel < 92) begin
      k = KIND_SEEK_RD;
      p = POS_W'($urandom_range(0, 2047));
    end else if (sel < 96) begin
      k = KIND_SEEK_WR;
      p = POS_W'($urandom_range(0, 2047));
    end else if (sel < 98) begin
      // Park a pointer at or just below the capacity edge.
      k = ($urandom_range(0, 1) == 0) ? KIND_SEEK_RD : KIND_SEEK_WR;
      p = POS_W'(CAPACITY_BITS - $urandom_range(0, 80));
    end else begin
      // Any 17-bit position, beyond capacity included.
      k = ($urandom_range(0, 1) == 0) ? KIND_SEEK_RD : KIND_SEEK_WR;
    end
    send_item(k, wc, rand_data(), p);
  endtask

  // Receiver: switch between always-ready, random stall runs and toggling,
  // and check every result the block hands over.
  int rx_mode = 0;
  int rx_mode_cycles = 0;
  int rx_stall_left = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_read_data, out_ok, out_read_position, out_write_position);
    end
    if (rx_mode_cycles == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_cycles = $urandom_range(20, 120);
    end
    rx_mode_cycles--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          rx_stall_left = $urandom_range(0, 23);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: out_ready <= ~out_ready;
    endcase
  end

  // Watchdog: end the run if nothing moves for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it; the block then clears its store on its own.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Every width, with all-ones and edge-bit data.
    send_item(KIND_WRITE, WCODE_1,  64'h1, rand_pos());
    send_item(KIND_WRITE, WCODE_8,  64'hFFFF_FFFF_FFFF_FFA5, '0);
    send_item(KIND_WRITE, WCODE_16, 64'hFFFF_FFFF_FFFF_FFFF, POS_MAX);
    send_item(KIND_WRITE, WCODE_32, 64'h0123_4567_DEAD_BEEF, '0);
    send_item(KIND_WRITE, WCODE_64, 64'h8000_0000_0000_0001, '0);
    send_item(KIND_READ,  WCODE_1,  '0, '0);
    send_item(KIND_READ,  WCODE_8,  64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(KIND_READ,  WCODE_16, '0, '0);
    send_item(KIND_READ,  WCODE_32, '0, '0);
    send_item(KIND_READ,  WCODE_64, '0, '0);
    // Read position has caught up with the write position: single bit refused.
    send_item(KIND_READ,  WCODE_1,  '0, '0);
    // Unused width codes change nothing.
    send_item(KIND_WRITE, WCODE_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(KIND_READ,  WCODE_SPARE_C, '0, '0);
    send_item(KIND_WRITE, WCODE_SPARE_B, '0, '0);
    // Fill up to the capacity edge, then overflow the write.
    send_item(KIND_SEEK_WR, WCODE_64, rand_data(), POS_W'(CAPACITY_BITS - 8));
    send_item(KIND_WRITE, WCODE_8,  64'h5A, '0);
    send_item(KIND_WRITE, WCODE_1,  64'h1, '0);
    // Read across the edge is refused; an exact fit is not.
    send_item(KIND_SEEK_RD, WCODE_1, '0, POS_W'(CAPACITY_BITS - 8));
    send_item(KIND_READ,  WCODE_16, '0, '0);
    send_item(KIND_READ,  WCODE_8,  '0, '0);
    // Seek beyond capacity; a single-bit read below it still fails on capacity.
    send_item(KIND_SEEK_WR, WCODE_SPARE_C, '0, POS_MAX);
    send_item(KIND_READ,  WCODE_1,  '0, '0);
    send_item(KIND_WRITE, WCODE_8,  64'hFF, '0);
    send_item(KIND_SEEK_RD, WCODE_1, '0, '0);
    send_item(KIND_SEEK_WR, WCODE_1, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_random_item();
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/bspb_pkg.sv
sv/bspb_ctrl.sv
sv/bspb_dp.sv
sv/bit_stream_pack_unpack_buffer.sv
verif/testbench.sv
